[sv/mst_edge_acceptor_union_find_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the MST edge acceptor
// Shared property templates for the checker, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MST_EDGE_ACCEPTOR_UNION_FIND_DEFINES_SVH
`define MST_EDGE_ACCEPTOR_UNION_FIND_DEFINES_SVH

// Same-cycle implication.
`define MEAUF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MEAUF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/meauf_pkg.sv]
// ----------------------------------------------------------------------------
// MST edge acceptor package
// Table size, payload types, controller states and control structs.
// ----------------------------------------------------------------------------
package meauf_pkg;

  localparam int MaxVertices = 256;
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int CfgW        = 9;
  localparam int SatW        = $clog2(MaxVertices + 1);
  localparam int EffW        = (SatW > CfgW) ? SatW : CfgW;
  localparam logic [CfgW-1:0] CountReset = CfgW'(256);

  typedef struct packed {
    logic              start_graph;
    logic [7:0]        from_vertex;
    logic [7:0]        to_vertex;
    logic signed [15:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              bad_vertex;
    logic signed [31:0] total_weight;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_COMP_CHK,
    ST_COMP_WR,
    ST_LINK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_cur;
    logic sel_to;
    logic rd_en;
    logic walk_next;
    logic set_root;
    logic comp_wr;
    logic save_ra;
    logic link;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic bad;
    logic cur_is_root;
    logic cur_at_root;
    logic out_busy;
  } ctl_status_t;

endpackage

[sv/meauf_ctrl.sv]
// ----------------------------------------------------------------------------
// MST edge acceptor controller
// Sequences root walks, path compression and linking for one edge.
// ----------------------------------------------------------------------------
module meauf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  meauf_pkg::ctl_status_t status_i,
  output meauf_pkg::ctl_cmd_t    cmd_o
);
  import meauf_pkg::*;

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.bad) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.load_cur = 1'b1;
          cmd_o.sel_to   = 1'b0;
          phase_d        = 1'b0;
          state_d        = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (status_i.cur_is_root) begin
          cmd_o.set_root = 1'b1;
          cmd_o.load_cur = 1'b1;
          cmd_o.sel_to   = phase_q;
          state_d        = ST_COMP_CHK;
        end else begin
          cmd_o.walk_next = 1'b1;
          state_d         = ST_WALK_RD;
        end
      end
      ST_COMP_CHK: begin
        if (status_i.cur_at_root) begin
          if (!phase_q) begin
            cmd_o.save_ra  = 1'b1;
            cmd_o.load_cur = 1'b1;
            cmd_o.sel_to   = 1'b1;
            phase_d        = 1'b1;
            state_d        = ST_WALK_RD;
          end else begin
            state_d = ST_LINK;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_COMP_WR;
        end
      end
      ST_COMP_WR: begin
        cmd_o.comp_wr = 1'b1;
        state_d       = ST_COMP_CHK;
      end
      ST_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/meauf_dpath.sv]
// ----------------------------------------------------------------------------
// MST edge acceptor datapath
// Parent-link memory with per-entry valid flags, walk registers, running
// total, vertex count register and result register.
// ----------------------------------------------------------------------------
module meauf_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  meauf_pkg::in_item_t        in_data_i,
  input  logic                       cfg_we_i,
  input  logic [meauf_pkg::CfgW-1:0] cfg_data_i,
  input  meauf_pkg::ctl_cmd_t        cmd_i,
  output meauf_pkg::ctl_status_t     status_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output meauf_pkg::out_item_t       out_data_o
);
  import meauf_pkg::*;

  logic [VtxW-1:0]        mem_q [MaxVertices];
  logic [MaxVertices-1:0] valid_q;
  logic [VtxW-1:0]        rd_data_q;
  logic [VtxW-1:0]        rd_addr_q;
  logic                   rd_valid_q;

  logic [CfgW-1:0]        count_q;
  in_item_t               item_q;
  logic [VtxW-1:0]        cur_q;
  logic [VtxW-1:0]        root_q;
  logic [VtxW-1:0]        ra_q;
  logic                   acc_q;
  logic signed [31:0]     total_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic [EffW-1:0]        eff_count;
  logic [VtxW-1:0]        parent;
  logic [VtxW-1:0]        endpoint;
  logic                   link_diff;
  logic                   wr_en;
  logic [VtxW-1:0]        wr_addr;
  logic                   clear;

  assign eff_count = (EffW'(count_q) > EffW'(MaxVertices)) ? EffW'(MaxVertices)
                                                           : EffW'(count_q);
  assign parent    = rd_valid_q ? rd_data_q : rd_addr_q;
  assign endpoint  = cmd_i.sel_to ? VtxW'(item_q.to_vertex) : VtxW'(item_q.from_vertex);
  assign link_diff = (root_q != ra_q);
  assign wr_en     = cmd_i.comp_wr || (cmd_i.link && link_diff);
  assign wr_addr   = cmd_i.comp_wr ? cur_q : ra_q;
  assign clear     = cmd_i.accept && in_data_i.start_graph;

  assign status_o.bad         = (EffW'(item_q.from_vertex) >= eff_count) ||
                                (EffW'(item_q.to_vertex) >= eff_count);
  assign status_o.cur_is_root = (parent == cur_q);
  assign status_o.cur_at_root = (cur_q == root_q);
  assign status_o.out_busy    = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= root_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cur_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear) begin
      for (int i = 0; i < MaxVertices; i++) begin
        if (EffW'(i) < eff_count) begin
          valid_q[i] <= 1'b0;
        end
      end
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_addr_q  <= cur_q;
      rd_valid_q <= valid_q[cur_q];
    end
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.load_cur) begin
      cur_q <= endpoint;
    end else if (cmd_i.walk_next || cmd_i.comp_wr) begin
      cur_q <= parent;
    end
    if (cmd_i.set_root) begin
      root_q <= cur_q;
    end
    if (cmd_i.save_ra) begin
      ra_q <= root_q;
    end
    if (cmd_i.load_out) begin
      out_q.accepted     <= acc_q;
      out_q.bad_vertex   <= status_o.bad;
      out_q.total_weight <= total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CountReset;
      total_q     <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        acc_q <= 1'b0;
        if (in_data_i.start_graph) begin
          total_q <= '0;
        end
      end else if (cmd_i.link && link_diff) begin
        acc_q   <= 1'b1;
        total_q <= total_q + {{16{item_q.edge_weight[15]}}, item_q.edge_weight};
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/mst_edge_acceptor_union_find.sv]
// ----------------------------------------------------------------------------
// MST edge acceptor with union-find
// Accepts sorted edges and reports whether each joins two components.
// ----------------------------------------------------------------------------
// An edge with a bad endpoint goes from the bound check straight to its result; any other
// edge runs root walks and path compression for both endpoints, then a link step, on the
// one read and one write port of the table. One edge is in work at a time; the
// next is taken the cycle after its result is registered, later if a stalled result waits.
// Reset: every table entry reads as a self-link through per-entry flags cleared at once,
// so there is no clearing pass; the total is zero and vertex_count 256.
module mst_edge_acceptor_union_find (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  meauf_pkg::in_item_t        in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output meauf_pkg::out_item_t       out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [meauf_pkg::CfgW-1:0] cfg_data_i
);
  import meauf_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  meauf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  meauf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/meauf_checker.sv]
// ----------------------------------------------------------------------------
// MST edge acceptor port checker
// Port-level properties of the edge acceptor, bound to the top level.
// ----------------------------------------------------------------------------
`include "mst_edge_acceptor_union_find_defines.svh"

module meauf_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_i,
  input logic                 out_valid_i,
  input logic                 out_stall_i,
  input meauf_pkg::out_item_t out_data_i
);

  // A stalled result holds its value until it is taken.
  `MEAUF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "stalled result changed")

  // Once an edge is taken the block is busy on the next cycle.
  `MEAUF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i, "input taken while an edge is in work")

  // A new result only appears at the end of an edge's work.
  `MEAUF_ASSERT_IMPL(a_result_from_work, clk_i, rst_ni, $rose(out_valid_i), $past(in_stall_i), "result without a transaction in work")

  // A bad endpoint is never reported as a tree edge.
  `MEAUF_ASSERT_IMPL(a_bad_not_taken, clk_i, rst_ni, out_valid_i && out_data_i.bad_vertex, !out_data_i.accepted, "bad edge reported as accepted")

endmodule

bind mst_edge_acceptor_union_find meauf_checker u_meauf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the MST edge acceptor
// Drives mostly sorted edge streams through the union-find stage under random idling
// on both sides, predicts each result with a parent-table model of its own and
// compares every result transaction field by field.
// ----------------------------------------------------------------------------
module tb;
  import meauf_pkg::*;

  localparam int CycleLimit   = 4_000_000;
  localparam int RandomEdges  = 700;
  localparam int SettleCycles = 16;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CfgW-1:0]   cfg_data  = '0;

  logic [7:0]        link_tbl [MaxVertices];
  logic [31:0]       tree_sum;
  logic [CfgW-1:0]   count_reg;
  out_item_t         pending_q[$];
  out_item_t         head;
  int                fails     = 0;
  int                cycle_cnt = 0;
  bit                calm      = 1'b0;

  typedef struct {
    bit              cfg_en;
    logic [CfgW-1:0] cfg_val;
    in_item_t        item;
    bit              typed;
    out_item_t       want;
  } edge_row_t;

  edge_row_t edge_rows[$];

  mst_edge_acceptor_union_find u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int live_count();
    return (int'(count_reg) > MaxVertices) ? MaxVertices : int'(count_reg);
  endfunction

  function automatic logic [7:0] find_root(logic [7:0] v);
    logic [7:0] r;
    logic [7:0] node;
    logic [7:0] nxt;
    int         steps;
    r = v;
    steps = 0;
    while (link_tbl[r] != r && steps < MaxVertices) begin
      r = link_tbl[r];
      steps++;
    end
    node = v;
    steps = 0;
    while (node != r && steps < MaxVertices) begin
      nxt = link_tbl[node];
      link_tbl[node] = r;
      node = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic out_item_t predict_edge(in_item_t e);
    out_item_t  r;
    logic [7:0] ra;
    logic [7:0] rb;
    int         lim;
    lim = live_count();
    r = '0;
    if (e.start_graph) begin
      for (int i = 0; i < lim; i++) link_tbl[i] = 8'(i);
      tree_sum = '0;
    end
    if (int'(e.from_vertex) >= lim || int'(e.to_vertex) >= lim) begin
      r.bad_vertex = 1'b1;
    end else begin
      ra = find_root(e.from_vertex);
      rb = find_root(e.to_vertex);
      if (ra != rb) begin
        link_tbl[ra] = rb;
        tree_sum = tree_sum + {{16{e.edge_weight[15]}}, e.edge_weight};
        r.accepted = 1'b1;
      end
    end
    r.total_weight = tree_sum;
    return r;
  endfunction

  function automatic void add_row(bit ce, int cv, bit st, int fv, int tv, int wv,
                                  bit ty, bit acc, bit bad, int tot);
    edge_row_t r;
    r.cfg_en                = ce;
    r.cfg_val               = CfgW'(cv);
    r.item.start_graph      = st;
    r.item.from_vertex      = 8'(fv);
    r.item.to_vertex        = 8'(tv);
    r.item.edge_weight      = 16'(wv);
    r.typed                 = ty;
    r.want.accepted         = acc;
    r.want.bad_vertex       = bad;
    r.want.total_weight     = 32'(tot);
    edge_rows.push_back(r);
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_count(logic [CfgW-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_reg = v;
  endtask

  task automatic send_edge(in_item_t e, bit typed, out_item_t want);
    int        gap;
    out_item_t p;
    gap = (!calm && $urandom_range(0, 99) < 25) ? int'($urandom_range(1, 5)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    do @(posedge clk); while (in_stall);
    p = predict_edge(e);
    pending_q.push_back(typed ? want : p);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result transaction with no expected result pending");
        fails++;
      end else begin
        head = pending_q.pop_front();
        if (out_data.accepted !== head.accepted) begin
          $error("accepted: expected %0d, got %0d", head.accepted, out_data.accepted);
          fails++;
        end
        if (out_data.bad_vertex !== head.bad_vertex) begin
          $error("bad_vertex: expected %0d, got %0d", head.bad_vertex, out_data.bad_vertex);
          fails++;
        end
        if (out_data.total_weight !== head.total_weight) begin
          $error("total_weight: expected %0d, got %0d", head.total_weight,
                 out_data.total_weight);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_item_t e;
    int       sent;
    int       phase;
    int       n_edges;
    int       lim;
    int       glen;
    int       wi;
    int       cval;
    bit       skip_start;

    for (int i = 0; i < MaxVertices; i++) link_tbl[i] = 8'(i);
    tree_sum  = '0;
    count_reg = CountReset;

    add_row(0,   0, 1,   0, 255, -32768, 1, 1, 0, -32768);
    add_row(0,   0, 0, 255,   0, -32768, 0, 0, 0, 0);
    add_row(0,   0, 0,   7,   7,      0, 0, 0, 0, 0);
    add_row(0,   0, 0,   1,   2,  32767, 0, 0, 0, 0);
    add_row(0,   0, 0,   0,   2,    100, 0, 0, 0, 0);
    add_row(0,   0, 0, 170,  85,     -1, 0, 0, 0, 0);
    add_row(1,   3, 1,   3,   0,      5, 1, 0, 1, 0);
    add_row(0,   0, 0,   0,   1,     -5, 0, 0, 0, 0);
    add_row(0,   0, 0,   2,   1,      7, 0, 0, 0, 0);
    add_row(0,   0, 0,   1,   0,      9, 0, 0, 0, 0);
    add_row(0,   0, 0,   0, 200,      1, 0, 0, 0, 0);
    add_row(1,   0, 0,   0,   0,      1, 0, 0, 0, 0);
    add_row(0,   0, 1,   0,   0,      1, 1, 0, 1, 0);
    add_row(1, 511, 1, 255, 254, -32768, 1, 1, 0, -32768);
    add_row(0,   0, 0, 254, 255,  32767, 0, 0, 0, 0);
    add_row(1,   1, 1,   0,   0,      3, 1, 0, 0, 0);
    add_row(0,   0, 0,   1,   0,      3, 1, 0, 1, 0);
    add_row(1,   4, 1,   0,   1,      2, 1, 1, 0, 2);
    add_row(0,   0, 0,   2,   3,      4, 0, 0, 0, 0);
    add_row(1,   8, 0,   5,   6,      1, 0, 0, 0, 0);
    add_row(0,   0, 0,   7,   0,      1, 0, 0, 0, 0);
    add_row(0,   0, 0,   3,   6,      2, 0, 0, 0, 0);
    add_row(1, 256, 1, 128, 127, -32768, 1, 1, 0, -32768);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (edge_rows[i]) begin
      if (edge_rows[i].cfg_en) set_count(edge_rows[i].cfg_val);
      send_edge(edge_rows[i].item, edge_rows[i].typed, edge_rows[i].want);
    end

    sent  = 0;
    phase = 0;
    while (sent < RandomEdges) begin
      case (phase % 6)
        0:       cval = 16;
        1:       cval = 2;
        2:       cval = 256;
        3:       cval = 64;
        4:       cval = 511;
        default: cval = $urandom_range(1, 511);
      endcase
      calm       = (phase == 4);
      skip_start = (phase % 4 == 3);
      set_count(CfgW'(cval));
      lim     = live_count();
      n_edges = 0;
      while (n_edges < 60 && sent < RandomEdges) begin
        glen = $urandom_range(4, 40);
        wi   = int'($urandom_range(0, 65535)) - 32768;
        for (int k = 0; k < glen; k++) begin
          e.start_graph = (k == 0 && !(skip_start && n_edges == 0)) ||
                          ($urandom_range(0, 99) < 2);
          e.from_vertex = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, lim - 1))
                                                      : 8'($urandom_range(0, 255));
          e.to_vertex   = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, lim - 1))
                                                      : 8'($urandom_range(0, 255));
          if ($urandom_range(0, 99) < 3) begin
            e.edge_weight = 16'($urandom);
          end else begin
            e.edge_weight = 16'(wi);
            wi = wi + int'($urandom_range(0, 400));
            if (wi > 32767) wi = 32767;
          end
          send_edge(e, 1'b0, '0);
          sent++;
          n_edges++;
        end
        if ($urandom_range(0, 4) == 0) drain_results();
      end
      phase++;
    end
    calm = 1'b0;

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/meauf_pkg.sv
sv/meauf_ctrl.sv
sv/meauf_dpath.sv
sv/mst_edge_acceptor_union_find.sv
sv/meauf_checker.sv
dv/tb.sv
